// File: hdl/see_pkg.sv
// shared types, constants and codes for the stack expression evaluator
// no dependencies; see_intf, see_div, see_front, see_back and the top level use this package
`default_nettype none

package see_pkg;

    // field widths
    localparam int SYM_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_PREFIX_MODE = 0;

    // default stack size
    localparam int STACK_DEPTH_DEF = 128;

    // front to back queue
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // divider: numerator is |left| shifted up by the Q16.16 scale
    localparam int FRAC_W    = 16;
    localparam int DIV_NUM_W = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // ascii codes
    localparam logic [SYM_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHR_SLASH = 8'h2F;

    // q16.16 constants
    localparam logic signed [DATA_W-1:0] NEG_ONE = 32'shFFFF_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // symbol classes
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_OTHER
    } op_t;

    // classified symbol as queued between front and back
    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
        logic       prefix;
    } q_item_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POP_A,
        BK_POP_B,
        BK_EXEC,
        BK_MUL,
        BK_DIV,
        BK_FIN_POP,
        BK_FIN_OUT
    } bk_state_t;

endpackage

`default_nettype wire

// File: hdl/see_intf.sv
// valid/ready stream interfaces for symbols in and results out
// depends on see_pkg for field widths
`default_nettype none

interface see_sym_if;
    logic                       valid;
    logic                       ready;
    logic [see_pkg::SYM_W-1:0]  symbol;
    logic                       last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface see_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [see_pkg::DATA_W-1:0]   value;
    logic [see_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/see_ram.sv
// generic single port write, single port read ram with registered read data
// no dependencies
`default_nettype none

module see_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/see_div.sv
// iterative restoring divider for unsigned magnitudes, one quotient bit a cycle
// depends on see_pkg for operand widths
`default_nettype none

module see_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [see_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [see_pkg::DATA_W-1:0]    den,
    output      logic                          done,
    output      logic [see_pkg::DIV_NUM_W-1:0] quo
);
    import see_pkg::*;

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DATA_W-1:0]    rem_reg,  rem_next;
    logic [DIV_NUM_W-1:0] quo_reg,  quo_next;
    logic [DATA_W-1:0]    den_reg,  den_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;
    logic                 ge;

    // one shift and trial subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    // iteration control
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: hdl/see_front.sv
// front end: accepts symbol transactions, classifies them, queues them
// depends on see_pkg and the see_sym_if interface
`default_nettype none

module see_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            prefix_mode,
    see_sym_if.sink              symbols,
    output      logic            q_valid,
    input  wire logic            q_ready,
    output      see_pkg::q_item_t q_item
);
    import see_pkg::*;

    q_item_t         fifo_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg,  count_next;
    logic            push;
    logic            pop;
    q_item_t         cls;

    // sort a symbol into digit or operator
    function automatic q_item_t classify(logic [SYM_W-1:0] sym, logic last, logic prefix);
        q_item_t     it;
        logic [SYM_W-1:0] off;
        off       = sym - CHR_ZERO;
        it.digit  = off[3:0];
        it.last   = last;
        it.prefix = prefix;
        if (sym >= CHR_ZERO && sym <= CHR_NINE)
        begin
            it.op = OP_DIGIT;
        end
        else
        begin
            case (sym)
                CHR_PLUS:  it.op = OP_ADD;
                CHR_MINUS: it.op = OP_SUB;
                CHR_STAR:  it.op = OP_MUL;
                CHR_SLASH: it.op = OP_DIV;
                default:   it.op = OP_OTHER;
            endcase
        end
        return it;
    endfunction

    function automatic logic [QP_W-1:0] ptr_inc(logic [QP_W-1:0] p);
        return (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // handshake
    assign symbols.ready = (count_reg != QC_W'(Q_DEPTH));
    assign push          = symbols.valid && symbols.ready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_item        = fifo_reg[rd_ptr_reg];
    assign cls           = classify(symbols.symbol, symbols.last_symbol, prefix_mode);

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QC_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on accept");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on hand-off");

endmodule

`default_nettype wire

// File: hdl/see_back.sv
// back end: operand stack in ram, arithmetic, result register
// depends on see_pkg, see_ram, see_div and the see_res_if interface
`default_nettype none

module see_back #(
    parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output      logic             q_ready,
    input  wire see_pkg::q_item_t q_item,
    see_res_if.source             results
);
    import see_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    bk_state_t               state_reg, state_next;
    logic [SP_W-1:0]         sp_reg,    sp_next;
    status_t                 status_reg, status_next;
    q_item_t                 item_reg;
    logic                    avail_reg, avail_next;
    logic signed [DATA_W-1:0] opa_reg;
    logic signed [63:0]      prod_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    status_t                 out_status_reg;

    // ram port
    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [DATA_W-1:0]       ram_rdata;

    // strobes
    logic                    take;
    logic                    push_req;
    logic signed [DATA_W-1:0] push_val;
    logic                    pop_req;
    logic                    flag_divz;
    logic                    div_start;
    logic                    mul_load;
    logic                    fin_load;
    logic                    out_free;

    // datapath
    logic signed [DATA_W-1:0] operand;
    logic signed [DATA_W-1:0] a_val;
    logic signed [DATA_W-1:0] b_val;
    logic signed [DATA_W:0]   add_sum;
    logic signed [DATA_W:0]   sub_dif;
    logic signed [DATA_W-1:0] divz_val;
    logic signed [63:0]       mul_adj;
    logic signed [63:0]       mul_shr;
    logic [DATA_W-1:0]        a_mag;
    logic [DATA_W-1:0]        b_mag;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quo;
    logic signed [DATA_W-1:0] div_val;
    logic [SP_W-1:0]          sp_dec;
    logic                     sp_full;
    logic                     sp_empty;
    bk_state_t                after_state;

    function automatic status_t flag(status_t cur, status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat33(logic signed [DATA_W:0] v);
        if (v[DATA_W] == v[DATA_W-1])
        begin
            return v[DATA_W-1:0];
        end
        return v[DATA_W] ? VAL_MIN : VAL_MAX;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat48(logic signed [DIV_NUM_W-1:0] v);
        if ((&v[DIV_NUM_W-1:DATA_W-1]) || !(|v[DIV_NUM_W-1:DATA_W-1]))
        begin
            return v[DATA_W-1:0];
        end
        return v[DIV_NUM_W-1] ? VAL_MIN : VAL_MAX;
    endfunction

    // operand stack
    see_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider for the divide operator
    see_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({a_mag, {FRAC_W{1'b0}}}),
        .den   (b_mag),
        .done  (div_done),
        .quo   (div_quo)
    );

    // operand selection and arithmetic
    always_comb
    begin
        operand  = avail_reg ? $signed(ram_rdata) : NEG_ONE;
        a_val    = item_reg.prefix ? opa_reg : operand;
        b_val    = item_reg.prefix ? operand : opa_reg;
        add_sum  = {a_val[DATA_W-1], a_val} + {b_val[DATA_W-1], b_val};
        sub_dif  = {a_val[DATA_W-1], a_val} - {b_val[DATA_W-1], b_val};
        a_mag    = a_val[DATA_W-1] ? (~a_val + 32'd1) : a_val;
        b_mag    = b_val[DATA_W-1] ? (~b_val + 32'd1) : b_val;
        if (a_val == '0)
        begin
            divz_val = '0;
        end
        else
        begin
            divz_val = a_val[DATA_W-1] ? VAL_MIN : VAL_MAX;
        end
        // truncate toward zero before the scale shift
        mul_adj  = prod_reg + (prod_reg[63] ? 64'sd65535 : 64'sd0);
        mul_shr  = mul_adj >>> FRAC_W;
        if (neg_reg)
        begin
            div_val = (div_quo > 48'h0000_8000_0000) ? VAL_MIN : (~div_quo[DATA_W-1:0] + 32'd1);
        end
        else
        begin
            div_val = (div_quo > 48'h0000_7FFF_FFFF) ? VAL_MAX : div_quo[DATA_W-1:0];
        end
    end

    assign sp_dec      = sp_reg - 1'b1;
    assign sp_full     = (sp_reg == SP_W'(STACK_DEPTH));
    assign sp_empty    = (sp_reg == '0);
    assign out_free    = !out_valid_reg || results.ready;
    assign q_ready     = (state_reg == BK_IDLE);
    assign take        = q_valid && q_ready;
    assign after_state = item_reg.last ? BK_FIN_POP : BK_IDLE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    if (q_item.op == OP_DIGIT)
                    begin
                        state_next = q_item.last ? BK_FIN_POP : BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_POP_A;
                    end
                end
            end
            BK_POP_A:   state_next = BK_POP_B;
            BK_POP_B:   state_next = BK_EXEC;
            BK_EXEC:
            begin
                case (item_reg.op)
                    OP_MUL:  state_next = BK_MUL;
                    OP_DIV:  state_next = (b_val == '0) ? after_state : BK_DIV;
                    default: state_next = after_state;
                endcase
            end
            BK_MUL:     state_next = after_state;
            BK_DIV:     state_next = div_done ? after_state : BK_DIV;
            BK_FIN_POP: state_next = BK_FIN_OUT;
            BK_FIN_OUT: state_next = out_free ? BK_IDLE : BK_FIN_OUT;
            default:    state_next = BK_IDLE;
        endcase
    end

    // strobes per state
    always_comb
    begin
        push_req  = 1'b0;
        push_val  = '0;
        pop_req   = 1'b0;
        flag_divz = 1'b0;
        div_start = 1'b0;
        mul_load  = 1'b0;
        fin_load  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (take && q_item.op == OP_DIGIT)
                begin
                    push_req = 1'b1;
                    push_val = {12'd0, q_item.digit, {FRAC_W{1'b0}}};
                end
            end
            BK_POP_A:   pop_req = 1'b1;
            BK_POP_B:   pop_req = 1'b1;
            BK_EXEC:
            begin
                case (item_reg.op)
                    OP_ADD:
                    begin
                        push_req = 1'b1;
                        push_val = sat33(add_sum);
                    end
                    OP_SUB:
                    begin
                        push_req = 1'b1;
                        push_val = sat33(sub_dif);
                    end
                    OP_MUL:     mul_load = 1'b1;
                    OP_DIV:
                    begin
                        if (b_val == '0)
                        begin
                            flag_divz = 1'b1;
                            push_req  = 1'b1;
                            push_val  = divz_val;
                        end
                        else
                        begin
                            div_start = 1'b1;
                        end
                    end
                    default:    push_req = 1'b0;
                endcase
            end
            BK_MUL:
            begin
                push_req = 1'b1;
                push_val = sat48(mul_shr[DIV_NUM_W-1:0]);
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    push_req = 1'b1;
                    push_val = div_val;
                end
            end
            BK_FIN_POP: pop_req = 1'b1;
            BK_FIN_OUT: fin_load = out_free;
            default:    push_req = 1'b0;
        endcase
    end

    // stack pointer, sticky status and ram access
    always_comb
    begin
        sp_next     = sp_reg;
        avail_next  = avail_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = sp_reg[AW-1:0];
        ram_raddr   = sp_dec[AW-1:0];
        if (flag_divz)
        begin
            status_next = flag(status_next, ST_DIVZ);
        end
        if (push_req)
        begin
            if (sp_full)
            begin
                status_next = flag(status_next, ST_OVER);
            end
            else
            begin
                ram_we  = 1'b1;
                sp_next = sp_reg + 1'b1;
            end
        end
        if (pop_req)
        begin
            if (sp_empty)
            begin
                status_next = flag(status_next, ST_UNDER);
                avail_next  = 1'b0;
            end
            else
            begin
                ram_re     = 1'b1;
                sp_next    = sp_dec;
                avail_next = 1'b1;
            end
        end
        if (fin_load)
        begin
            sp_next     = '0;
            status_next = ST_OK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sp_reg        <= '0;
            status_reg    <= ST_OK;
            avail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
            avail_reg  <= avail_next;
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= q_item;
        end
        if (state_reg == BK_POP_B)
        begin
            opa_reg <= operand;
        end
        if (mul_load)
        begin
            prod_reg <= a_val * b_val;
        end
        if (div_start)
        begin
            neg_reg <= a_val[DATA_W-1] ^ b_val[DATA_W-1];
        end
        if (fin_load)
        begin
            out_value_reg  <= operand;
            out_status_reg <= status_reg;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = out_value_reg;
    assign results.status = out_status_reg;

    // checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != ST_OK && !fin_load) |=> (status_reg == $past(status_reg)))
        else $error("sticky status changed before the result");

    a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |=> (sp_reg == '0 && status_reg == ST_OK && out_valid_reg))
        else $error("stack not cleared after the result");

endmodule

`default_nettype wire

// File: hdl/stack_expression_evaluator.sv
// Stack expression evaluator. Symbols arrive one per transaction on the
// symbols channel, a digit pushes its value and an operator pops two operands
// and pushes the Q16.16 result; the transaction flagged last_symbol also pops
// the top and sends value and sticky status on the results channel. A two
// entry queue lets the front take symbols while the back works. In the back,
// a digit is pushed as it is accepted; add, subtract and unknown symbols go
// through the accept, two registered stack ram reads and the execute step,
// multiply adds a registered product step, and divide waits for the one bit
// per cycle divider over 48 quotient bits. A last symbol adds the final pop
// and the result load, which waits while the results channel is stalled.
// prefix_mode is register 0 at byte address 0 of the APB port.
// depends on see_pkg, see_intf, see_front, see_back
`default_nettype none

module stack_expression_evaluator #(
    parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [see_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [see_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [see_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready,
    see_sym_if.sink                             symbols,
    see_res_if.source                           results
);
    import see_pkg::*;

    logic    prefix_mode_reg, prefix_mode_next;
    logic    reg_sel;
    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == 1'(REG_PREFIX_MODE));

    always_comb
    begin
        prefix_mode_next = prefix_mode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            prefix_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_mode_reg <= 1'b0;
        end
        else
        begin
            prefix_mode_reg <= prefix_mode_next;
        end
    end

    assign prdata = reg_sel ? {{(APB_DATA_W-1){1'b0}}, prefix_mode_reg} : '0;

    // symbol intake and classification
    see_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .prefix_mode (prefix_mode_reg),
        .symbols     (symbols),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // stack and arithmetic
    see_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .results (results)
    );

endmodule

`default_nettype wire
